### rtl/mcmd_pkg.sv
// Shared types and constants for the MIDI channel message decoder.
package mcmd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CC_COUNT_W      = 16;
    localparam int CC_IDX_W        = 7;
    localparam int CC_DEPTH        = 1 << CC_IDX_W;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int BEND_W          = 21;
    localparam int RANGE_W         = 5;

    localparam logic [RANGE_W-1:0] BEND_RANGE_RESET = 5'd2;
    localparam logic [RANGE_W-1:0] BEND_RANGE_MAX   = 5'd24;
    localparam logic signed [15:0] BEND_CENTRE      = 16'sd8192;

    localparam logic [7:0] ST_TYPE_MASK = 8'hF0;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_CTRL      = 8'hB0;
    localparam logic [7:0] ST_PROGRAM   = 8'hC0;
    localparam logic [7:0] ST_PRESSURE  = 8'hD0;
    localparam logic [7:0] ST_BEND      = 8'hE0;

    localparam logic [7:0] CC_MOD        = 8'd1;
    localparam logic [7:0] CC_PORTA      = 8'd5;
    localparam logic [7:0] CC_SUSTAIN    = 8'd64;
    localparam logic [7:0] CC_SOUND_OFF  = 8'd120;
    localparam logic [7:0] CC_NOTES_OFF  = 8'd123;
    localparam logic [7:0] PEDAL_THRESH  = 8'd64;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_SKIP  = 2'd1,
        PH_DATA1 = 2'd2,
        PH_DATA2 = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NOTE_ON  = 3'd1,
        EV_NOTE_OFF = 3'd2,
        EV_SUSTAIN  = 3'd3,
        EV_ALL_OFF  = 3'd4,
        EV_MOD      = 3'd5,
        EV_PORTA    = 3'd6,
        EV_BEND     = 3'd7
    } t_event;

    // Classified message handed from parser to executor
    typedef struct packed {
        t_event     kind;
        logic       is_cc;
        logic       pedal;
        logic [7:0] key;
        logic [7:0] value;
    } t_msg;

endpackage

### rtl/mcmd_ifs.sv
// Valid/ready channel interfaces for MIDI bytes in and decoded events out.
interface mcmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;
    logic       end_of_buffer;

    modport source (output valid, output midi_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input midi_byte, input end_of_buffer, output ready);
endinterface

interface mcmd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [7:0]         key;
    logic [7:0]         value;
    logic               pedal_down;
    logic signed [20:0] bend_amount;
    logic [15:0]        cc_count;
    logic [7:0]         last_note;

    modport source (output valid, output event_kind, output key, output value,
                    output pedal_down, output bend_amount, output cc_count,
                    output last_note, input ready);
    modport sink   (input valid, input event_kind, input key, input value,
                    input pedal_down, input bend_amount, input cc_count,
                    input last_note, output ready);
endinterface

### rtl/mcmd_front.sv
// Byte parser: tracks message phase and classifies each byte into a message record.
module mcmd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcmd_in_if.sink         i_in,
    output logic            o_msg_valid,
    input  logic            i_msg_ready,
    output mcmd_pkg::t_msg  o_msg
);

    mcmd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_status, n_status;
    logic [7:0]       r_first, n_first;
    logic [7:0]       b;
    logic [7:0]       st_type;
    logic             accept;

    assign b           = i_in.midi_byte;
    assign st_type     = r_status & mcmd_pkg::ST_TYPE_MASK;
    assign o_msg_valid = i_in.valid;
    assign i_in.ready  = i_msg_ready;
    assign accept      = i_in.valid && i_msg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mcmd_pkg::PH_WAIT;
            r_status <= '0;
            r_first  <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_first  <= n_first;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_first  = r_first;
        o_msg    = '{kind: mcmd_pkg::EV_NONE, is_cc: 1'b0, pedal: 1'b0,
                     key: 8'd0, value: 8'd0};
        unique case (r_phase)
            mcmd_pkg::PH_WAIT: begin
                if (b[7]) begin
                    n_status = b;
                    if ((b & mcmd_pkg::ST_TYPE_MASK) == mcmd_pkg::ST_PROGRAM ||
                        (b & mcmd_pkg::ST_TYPE_MASK) == mcmd_pkg::ST_PRESSURE) begin
                        n_phase = mcmd_pkg::PH_SKIP;
                    end else begin
                        n_phase = mcmd_pkg::PH_DATA1;
                    end
                end
            end
            mcmd_pkg::PH_SKIP: begin
                n_phase = mcmd_pkg::PH_WAIT;
            end
            mcmd_pkg::PH_DATA1: begin
                n_first = b;
                n_phase = mcmd_pkg::PH_DATA2;
            end
            mcmd_pkg::PH_DATA2: begin
                n_phase     = mcmd_pkg::PH_WAIT;
                o_msg.key   = r_first;
                o_msg.value = b;
                unique case (st_type)
                    mcmd_pkg::ST_NOTE_ON: begin
                        o_msg.kind = (b == 8'd0) ? mcmd_pkg::EV_NOTE_OFF
                                                 : mcmd_pkg::EV_NOTE_ON;
                    end
                    mcmd_pkg::ST_NOTE_OFF: o_msg.kind = mcmd_pkg::EV_NOTE_OFF;
                    mcmd_pkg::ST_CTRL: begin
                        o_msg.is_cc = 1'b1;
                        unique case (r_first) inside
                            mcmd_pkg::CC_SUSTAIN: begin
                                o_msg.kind  = mcmd_pkg::EV_SUSTAIN;
                                o_msg.pedal = (b >= mcmd_pkg::PEDAL_THRESH);
                            end
                            mcmd_pkg::CC_SOUND_OFF, mcmd_pkg::CC_NOTES_OFF:
                                o_msg.kind = mcmd_pkg::EV_ALL_OFF;
                            mcmd_pkg::CC_MOD:   o_msg.kind = mcmd_pkg::EV_MOD;
                            mcmd_pkg::CC_PORTA: o_msg.kind = mcmd_pkg::EV_PORTA;
                            default:            o_msg.kind = mcmd_pkg::EV_NONE;
                        endcase
                    end
                    mcmd_pkg::ST_BEND: o_msg.kind = mcmd_pkg::EV_BEND;
                    default:           o_msg.kind = mcmd_pkg::EV_NONE;
                endcase
            end
            default: n_phase = mcmd_pkg::PH_WAIT;
        endcase
        // buffer end drops any partial message or pending skip
        if (i_in.end_of_buffer) begin
            n_phase = mcmd_pkg::PH_WAIT;
        end
    end

endmodule

### rtl/mcmd_fifo.sv
// Short message queue between the parser and the executor.
module mcmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  mcmd_pkg::t_msg  i_push_msg,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output mcmd_pkg::t_msg  o_pop_msg
);

    mcmd_pkg::t_msg                r_mem [mcmd_pkg::QUEUE_DEPTH];
    logic [mcmd_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [mcmd_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [mcmd_pkg::QPTR_W:0]     r_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_count != (mcmd_pkg::QPTR_W + 1)'(mcmd_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_msg    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/mcmd_back.sv
// Executor: CC count memory, pitch bend scaling, last note and the result register.
module mcmd_back #(
    parameter int COUNT_WIDTH = mcmd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcmd_pkg::RANGE_W-1:0]   i_cfg_wdata,
    input  logic                           i_msg_valid,
    output logic                           o_msg_ready,
    input  mcmd_pkg::t_msg                 i_msg,
    mcmd_out_if.source                     o_out
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0]            r_cnt_mem [mcmd_pkg::CC_DEPTH];
    logic [mcmd_pkg::CC_DEPTH-1:0]     r_cnt_vld;
    logic [mcmd_pkg::RANGE_W-1:0]      r_bend_range;
    logic [7:0]                        r_recent;

    // issue stage
    logic                              r_s1_vld;
    mcmd_pkg::t_msg                    r_s1_msg;
    logic [COUNT_WIDTH-1:0]            r_rd_cnt;
    logic                              r_rd_hit;

    // result register
    logic                              r_out_vld;
    mcmd_pkg::t_event                  r_out_kind;
    logic [7:0]                        r_out_key;
    logic [7:0]                        r_out_value;
    logic                              r_out_pedal;
    logic signed [mcmd_pkg::BEND_W-1:0] r_out_bend;
    logic [mcmd_pkg::CC_COUNT_W-1:0]   r_out_cnt;
    logic [7:0]                        r_out_note;

    logic                              out_free;
    logic                              s1_adv;
    logic                              s1_free;
    logic                              issue;
    logic [mcmd_pkg::CC_IDX_W-1:0]     s1_idx;
    logic [mcmd_pkg::CC_IDX_W-1:0]     q_idx;
    logic [COUNT_WIDTH-1:0]            cur_cnt;
    logic [COUNT_WIDTH-1:0]            n_cnt;
    logic [14:0]                       raw_bend;
    logic signed [15:0]                centred;
    logic signed [21:0]                bend_prod;
    logic [7:0]                        n_recent;

    assign out_free    = !r_out_vld || o_out.ready;
    assign s1_adv      = r_s1_vld && out_free;
    assign s1_free     = !r_s1_vld || s1_adv;
    assign o_msg_ready = s1_free;
    assign issue       = i_msg_valid && s1_free;

    assign s1_idx = r_s1_msg.key[mcmd_pkg::CC_IDX_W-1:0];
    assign q_idx  = i_msg.key[mcmd_pkg::CC_IDX_W-1:0];

    always_comb begin
        cur_cnt   = r_rd_hit ? r_rd_cnt : '0;
        n_cnt     = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
        raw_bend  = {r_s1_msg.value, 7'd0} | {7'd0, r_s1_msg.key};
        centred   = $signed({1'b0, raw_bend}) - mcmd_pkg::BEND_CENTRE;
        bend_prod = 22'(centred) * $signed({17'd0, r_bend_range});
        n_recent  = (r_s1_msg.kind == mcmd_pkg::EV_NOTE_ON) ? r_s1_msg.key : r_recent;
    end

    // count memory: write from the executing item, read for the issuing one
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_msg.is_cc) begin
            r_cnt_mem[s1_idx] <= n_cnt;
        end
        if (issue) begin
            // forward the count being written this cycle to the same CC number
            if (s1_adv && r_s1_msg.is_cc && s1_idx == q_idx) begin
                r_rd_cnt <= n_cnt;
                r_rd_hit <= 1'b1;
            end else begin
                r_rd_cnt <= r_cnt_mem[q_idx];
                r_rd_hit <= r_cnt_vld[q_idx];
            end
            r_s1_msg <= i_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld    <= '0;
            r_bend_range <= mcmd_pkg::BEND_RANGE_RESET;
            r_recent     <= '0;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bend_range <= (i_cfg_wdata > mcmd_pkg::BEND_RANGE_MAX)
                                ? mcmd_pkg::BEND_RANGE_MAX : i_cfg_wdata;
            end
            if (s1_adv && r_s1_msg.is_cc) begin
                r_cnt_vld[s1_idx] <= 1'b1;
            end
            if (s1_adv) begin
                r_recent <= n_recent;
            end
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_kind  <= r_s1_msg.kind;
            r_out_key   <= r_s1_msg.key;
            r_out_value <= r_s1_msg.value;
            r_out_pedal <= r_s1_msg.pedal;
            r_out_bend  <= (r_s1_msg.kind == mcmd_pkg::EV_BEND)
                           ? bend_prod[mcmd_pkg::BEND_W-1:0] : '0;
            r_out_cnt   <= r_s1_msg.is_cc ? mcmd_pkg::CC_COUNT_W'(n_cnt) : '0;
            r_out_note  <= n_recent;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.event_kind  = r_out_kind;
    assign o_out.key         = r_out_key;
    assign o_out.value       = r_out_value;
    assign o_out.pedal_down  = r_out_pedal;
    assign o_out.bend_amount = r_out_bend;
    assign o_out.cc_count    = r_out_cnt;
    assign o_out.last_note   = r_out_note;

endmodule

### rtl/midi_channel_message_decoder.sv
// MIDI channel message decoder: one result item per byte, 1 byte per cycle sustained
// while the output is not stalled. Each byte goes through the queue, the issue stage
// with the count memory read, and the result register before its result shows.
// Throughput: one byte per cycle until a stalled output has filled the 2-entry queue.
// Reset (synchronous, active low): parser waits for status, CC counts read as zero
// at once through per-entry valid bits (no clearing pass), bend range returns to 2.
module midi_channel_message_decoder #(
    parameter int COUNT_WIDTH = mcmd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcmd_pkg::RANGE_W-1:0]   i_cfg_wdata,
    mcmd_in_if.sink                        i_byte,
    mcmd_out_if.source                     o_event
);

    logic           front_valid;
    logic           front_ready;
    mcmd_pkg::t_msg front_msg;
    logic           q_valid;
    logic           q_ready;
    mcmd_pkg::t_msg q_msg;

    mcmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_byte),
        .o_msg_valid (front_valid),
        .i_msg_ready (front_ready),
        .o_msg       (front_msg)
    );

    mcmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_msg   (front_msg),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_msg    (q_msg)
    );

    mcmd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_msg_valid (q_valid),
        .o_msg_ready (q_ready),
        .i_msg       (q_msg),
        .o_out       (o_event)
    );

endmodule

### tb/mcmd_event_checker.sv
// Checker for the MIDI decoder: predicts every result item and compares it with the block.
module mcmd_event_checker
    import mcmd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [RANGE_W-1:0] i_cfg_wdata,
    mcmd_in_if                 i_byte,
    mcmd_out_if                i_event,
    output int unsigned        o_fail_count,
    output int unsigned        o_outstanding,
    output int unsigned        o_checked,
    output int unsigned        o_event_items
);

    localparam int TALLY_W = COUNT_WIDTH_DEF;

    typedef struct packed {
        t_event                   kind;
        logic [7:0]               key;
        logic [7:0]               value;
        logic                     pedal;
        logic signed [BEND_W-1:0] bend;
        logic [CC_COUNT_W-1:0]    cc_count;
        logic [7:0]               last_note;
    } t_decoded;

    t_phase             parse_phase;
    logic [7:0]         status_hold;
    logic [7:0]         first_data_hold;
    logic [TALLY_W-1:0] cc_tally [CC_DEPTH];
    logic [7:0]         note_memory;
    logic [RANGE_W-1:0] bend_semitones;
    t_decoded           due_events [$];
    int unsigned        fails = 0;
    int unsigned        checked = 0;
    int unsigned        event_items = 0;

    // Advance the parser by one byte and return the result item it causes.
    function automatic t_decoded decode_byte(input logic [7:0] b, input logic eob);
        t_decoded             ev;
        logic [7:0]           status_type;
        logic [CC_IDX_W-1:0]  idx;
        int                   raw;
        int                   amt;
        ev = '0;
        case (parse_phase)
            PH_WAIT: begin
                if (b[7]) begin
                    status_hold = b;
                    status_type = b & ST_TYPE_MASK;
                    parse_phase = (status_type == ST_PROGRAM || status_type == ST_PRESSURE)
                                  ? PH_SKIP : PH_DATA1;
                end
            end
            PH_SKIP: parse_phase = PH_WAIT;
            PH_DATA1: begin
                first_data_hold = b;
                parse_phase = PH_DATA2;
            end
            default: begin
                ev.key = first_data_hold;
                ev.value = b;
                parse_phase = PH_WAIT;
                case (status_hold & ST_TYPE_MASK)
                    ST_NOTE_ON: begin
                        if (b == 8'd0) begin
                            ev.kind = EV_NOTE_OFF;
                        end else begin
                            ev.kind = EV_NOTE_ON;
                            note_memory = first_data_hold;
                        end
                    end
                    ST_NOTE_OFF: ev.kind = EV_NOTE_OFF;
                    ST_CTRL: begin
                        // count by the low seven bits, but decode on the whole byte
                        idx = first_data_hold[CC_IDX_W-1:0];
                        if (cc_tally[idx] != '1)
                            cc_tally[idx] = cc_tally[idx] + 1'b1;
                        ev.cc_count = cc_tally[idx][CC_COUNT_W-1:0];
                        case (first_data_hold)
                            CC_SUSTAIN: begin
                                ev.kind = EV_SUSTAIN;
                                ev.pedal = (b >= PEDAL_THRESH);
                            end
                            CC_SOUND_OFF, CC_NOTES_OFF: ev.kind = EV_ALL_OFF;
                            CC_MOD: ev.kind = EV_MOD;
                            CC_PORTA: ev.kind = EV_PORTA;
                            default: ;
                        endcase
                    end
                    ST_BEND: begin
                        // bit 7 of the first byte overlaps bit 0 of the second
                        raw = (int'(b) << 7) | int'(first_data_hold);
                        amt = (raw - int'(BEND_CENTRE)) * int'(bend_semitones);
                        ev.kind = EV_BEND;
                        ev.bend = amt[BEND_W-1:0];
                    end
                    default: ;
                endcase
            end
        endcase
        if (eob)
            parse_phase = PH_WAIT;
        ev.last_note = note_memory;
        return ev;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_decoded want;
        if (!i_rst_n) begin
            parse_phase = PH_WAIT;
            status_hold = '0;
            first_data_hold = '0;
            note_memory = '0;
            bend_semitones = BEND_RANGE_RESET;
            for (int i = 0; i < CC_DEPTH; i++)
                cc_tally[i] = '0;
            due_events.delete();
        end else begin
            // compare before predicting: a new item cannot match a result in the same cycle
            if (i_event.valid && i_event.ready) begin
                checked++;
                if (due_events.size() == 0) begin
                    $error("result item arrived with no item waiting for it");
                    fails++;
                end else begin
                    want = due_events.pop_front();
                    check_field("event_kind", int'(want.kind), int'(i_event.event_kind));
                    check_field("key", int'(want.key), int'(i_event.key));
                    check_field("value", int'(want.value), int'(i_event.value));
                    check_field("pedal_down", int'(want.pedal), int'(i_event.pedal_down));
                    check_field("bend_amount", int'(want.bend), int'(i_event.bend_amount));
                    check_field("cc_count", int'(want.cc_count), int'(i_event.cc_count));
                    check_field("last_note", int'(want.last_note), int'(i_event.last_note));
                    if (want.kind != EV_NONE)
                        event_items++;
                end
            end
            if (i_cfg_we)
                bend_semitones = (i_cfg_wdata > BEND_RANGE_MAX) ? BEND_RANGE_MAX : i_cfg_wdata;
            if (i_byte.valid && i_byte.ready)
                due_events.push_back(decode_byte(i_byte.midi_byte, i_byte.end_of_buffer));
        end
        o_fail_count  <= fails;
        o_outstanding <= due_events.size();
        o_checked     <= checked;
        o_event_items <= event_items;
    end

endmodule

### tb/tb.sv
// Testbench top for the MIDI decoder: drives bytes and bend range writes, gives the verdict.
module tb;
    import mcmd_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASE_BYTES     = 290;
    localparam int CC_BURST_MSGS   = 40;

    localparam logic [7:0] ST_POLY_PRESSURE = 8'hA0;
    localparam logic [7:0] ST_SYSTEM        = 8'hF0;
    localparam logic [7:0] CC_VOLUME        = 8'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [RANGE_W-1:0] cfg_wdata;

    mcmd_in_if  byte_ch ();
    mcmd_out_if event_ch ();

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned event_items;
    int unsigned bytes_sent = 0;
    int unsigned burst_bytes = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          stall_left = 0;

    midi_channel_message_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_byte      (byte_ch),
        .o_event     (event_ch)
    );

    mcmd_event_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_byte        (byte_ch),
        .i_event       (event_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_event_items (event_items)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(0, 127));
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0:       return 8'h00;
                1:       return 8'h7F;
                2:       return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(128, 255));
    endfunction

    function automatic logic [7:0] pick_status_type();
        case ($urandom_range(0, 11))
            0:       return ST_NOTE_OFF;
            1, 2:    return ST_NOTE_ON;
            3, 4, 5: return ST_CTRL;
            6:       return ST_PROGRAM;
            7:       return ST_PRESSURE;
            8, 9:    return ST_BEND;
            10:      return ST_POLY_PRESSURE;
            default: return ST_SYSTEM;
        endcase
    endfunction

    // decoded numbers, 0 and 127, and aliases with bit 7 set of four decoded ones
    function automatic logic [7:0] pick_cc_number();
        case ($urandom_range(0, 10))
            0:       return CC_MOD;
            1:       return CC_PORTA;
            2:       return CC_SUSTAIN;
            3:       return CC_SOUND_OFF;
            4:       return CC_NOTES_OFF;
            5:       return 8'd0;
            6:       return 8'd127;
            7:       return CC_SUSTAIN | 8'h80;
            8:       return CC_MOD | 8'h80;
            9:       return CC_SOUND_OFF | 8'h80;
            default: return CC_NOTES_OFF | 8'h80;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still awaited", cycle_count,
                     outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sink side: hold ready low for a stall, else raise it and maybe start a new stall
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            event_ch.ready <= 1'b0;
        end else begin
            event_ch.ready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 15)
                stall_left = pick_gap();
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.midi_byte <= b;
        byte_ch.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_msg3(input logic [7:0] status, input logic [7:0] first,
                             input logic [7:0] second, input logic eob);
        send_byte(status, 1'b0);
        send_byte(first, 1'b0);
        send_byte(second, eob);
    endtask

    task automatic send_random_message();
        logic [7:0] msg [3];
        logic [7:0] status_type;
        int         len;
        logic       eob;
        if ($urandom_range(0, 99) < 10) begin
            send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        status_type = pick_status_type();
        msg[0] = status_type | {4'h0, 4'($urandom)};
        msg[1] = rand_data();
        msg[2] = rand_data();
        if (status_type == ST_CTRL && $urandom_range(0, 99) < 60) begin
            msg[1] = pick_cc_number();
            if (msg[1] == CC_SUSTAIN && $urandom_range(0, 1) == 0)
                msg[2] = 8'($urandom_range(PEDAL_THRESH - 2, PEDAL_THRESH + 1));
        end
        if (status_type == ST_NOTE_ON && $urandom_range(0, 99) < 20)
            msg[2] = 8'd0;
        len = (status_type == ST_PROGRAM || status_type == ST_PRESSURE) ? 2 : 3;
        for (int i = 0; i < len; i++) begin
            eob = (i == len - 1) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 29) == 0);
            send_byte(msg[i], eob);
            // a buffer end mid-message drops the rest
            if (eob)
                break;
        end
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 49) == 0) begin
                gaps_on = ($urandom_range(0, 2) != 0);
                stalls_on = ($urandom_range(0, 2) != 0);
            end
            send_random_message();
        end
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bend_range(input logic [RANGE_W-1:0] range);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= range;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // back to back control changes on one number
    task automatic cc_count_burst();
        int unsigned start;
        start = bytes_sent;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (CC_BURST_MSGS)
            send_msg3(ST_CTRL | {4'h0, 4'($urandom)}, CC_VOLUME, rand_data(), 1'b0);
        burst_bytes = bytes_sent - start;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        byte_ch.valid = 1'b0;
        byte_ch.midi_byte = '0;
        byte_ch.end_of_buffer = 1'b0;
        event_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // opening sequence at the reset bend range
        send_byte(8'h05, 1'b0);
        send_msg3(ST_NOTE_ON, 8'd60, 8'd100, 1'b0);
        send_msg3(ST_NOTE_ON, 8'd60, 8'd0, 1'b0);
        send_msg3(ST_NOTE_OFF | 8'h0F, 8'hFF, 8'hFF, 1'b0);
        send_msg3(ST_CTRL, CC_SUSTAIN, PEDAL_THRESH, 1'b0);
        send_msg3(ST_CTRL, CC_SUSTAIN | 8'h80, 8'd0, 1'b0);
        send_msg3(ST_BEND, 8'h00, 8'h00, 1'b0);
        send_msg3(ST_BEND | 8'h0F, 8'hFF, 8'hFF, 1'b0);
        send_byte(ST_PROGRAM, 1'b0);
        send_byte(ST_NOTE_ON, 1'b0);
        send_byte(ST_CTRL, 1'b0);
        send_byte(CC_SOUND_OFF, 1'b1);
        send_byte(8'h40, 1'b0);
        send_byte(ST_PRESSURE, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_msg3(ST_POLY_PRESSURE, 8'h11, 8'h22, 1'b0);
        send_msg3(ST_SYSTEM, 8'hFF, 8'h00, 1'b1);

        write_bend_range(BEND_RANGE_MAX);
        random_phase(PHASE_BYTES);
        write_bend_range('0);
        random_phase(PHASE_BYTES);
        write_bend_range('1);
        random_phase(PHASE_BYTES);
        write_bend_range(RANGE_W'($urandom));
        random_phase(PHASE_BYTES);
        write_bend_range(BEND_RANGE_MAX + 1'b1);
        cc_count_burst();
        write_bend_range(BEND_RANGE_RESET);
        random_phase(PHASE_BYTES);
        drain_results();

        $display("sent %0d bytes over several bend range settings, %0d of them in the CC burst",
                 bytes_sent, burst_bytes);
        $display("checked %0d result items, %0d carrying an event", checked, event_items);
        if (fail_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
rtl/mcmd_pkg.sv
rtl/mcmd_ifs.sv
rtl/mcmd_front.sv
rtl/mcmd_fifo.sv
rtl/mcmd_back.sv
rtl/midi_channel_message_decoder.sv
tb/mcmd_event_checker.sv
tb/tb.sv
